// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl of the date decrement block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/gdd_pkg.sv -----
// types, constants and calendar helpers of the date decrement block
`default_nettype none

package gdd_pkg;

  localparam int COUNT_BITS_DEF = 12;

  // year bits folded into the mod-25 residue after the sign bit
  localparam int RES_BITS = 15;

  localparam logic [4:0]  RES_MOD  = 5'd25;
  // residue of 32767 mod 25, taken when the year wraps from -32768
  localparam logic [4:0]  RES_WRAP = 5'd17;
  localparam logic [15:0] YEAR_MIN = 16'h8000;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_LAST  = 5'd31;

  typedef enum logic [2:0] {
    MODE_DAY        = 3'd0,
    MODE_WEEK       = 3'd1,
    MODE_MONTH      = 3'd2,
    MODE_YEAR       = 3'd3,
    MODE_DECADE     = 3'd4,
    MODE_CENTURY    = 3'd5,
    MODE_MILLENNIUM = 3'd6,
    MODE_NONE       = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    OP_DAY,
    OP_MONTH,
    OP_RES
  } step_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RES,
    ST_STEP,
    ST_DONE
  } state_t;

  // working date plus the year's residue mod 25
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [4:0]  res;
  } date_t;

  // divisible by 4, and by 25 only together with 16
  function automatic logic is_leap(input logic [15:0] year, input logic [4:0] res);
    return (year[1:0] == 2'b00) && ((res != 5'd0) || (year[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = DAY_LAST;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = DAY_LAST;
    endcase
    return len;
  endfunction

  function automatic logic [15:0] year_scale(input mode_t mode);
    logic [15:0] k;
    k = 16'd1;
    unique case (mode)
      MODE_DECADE:     k = 16'd10;
      MODE_CENTURY:    k = 16'd100;
      MODE_MILLENNIUM: k = 16'd1000;
      default:         k = 16'd1;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gdd_step.sv -----
// shared step unit: one day back, one month back, or one residue bit
`default_nettype none

module gdd_step (
  input  var gdd_pkg::step_op_t op,
  input  var gdd_pkg::date_t    cur,
  input  wire logic             bit_in,
  output gdd_pkg::date_t        nxt
);

  logic       leap;
  logic [4:0] res_dec;
  logic [5:0] res_dbl;
  logic [4:0] len;
  logic [3:0] month_prev;

  always_comb begin
    leap       = gdd_pkg::is_leap(cur.year, cur.res);
    res_dec    = (cur.year == gdd_pkg::YEAR_MIN) ? gdd_pkg::RES_WRAP :
                 ((cur.res == 5'd0) ? (gdd_pkg::RES_MOD - 5'd1) : (cur.res - 5'd1));
    res_dbl    = {cur.res, bit_in};
    month_prev = cur.month - 4'd1;
    len        = gdd_pkg::month_days(month_prev, leap);
    nxt        = cur;
    unique case (op)
      gdd_pkg::OP_DAY: begin
        if (cur.day <= 5'd1) begin
          if (cur.month <= gdd_pkg::MONTH_JAN) begin
            nxt.month = gdd_pkg::MONTH_DEC;
            nxt.day   = gdd_pkg::DAY_LAST;
            nxt.year  = cur.year - 16'd1;
            nxt.res   = res_dec;
          end else begin
            nxt.month = month_prev;
            nxt.day   = len;
          end
        end else begin
          nxt.day = cur.day - 5'd1;
        end
      end
      gdd_pkg::OP_MONTH: begin
        if (cur.month <= gdd_pkg::MONTH_JAN) begin
          nxt.month = gdd_pkg::MONTH_DEC;
          nxt.year  = cur.year - 16'd1;
          nxt.res   = res_dec;
          // december is always 31 days, nothing to clamp
        end else begin
          nxt.month = month_prev;
          if (cur.day > len) begin
            nxt.day = len;
          end
        end
      end
      gdd_pkg::OP_RES: begin
        nxt.res = (res_dbl >= {1'b0, gdd_pkg::RES_MOD}) ?
                  5'(res_dbl - {1'b0, gdd_pkg::RES_MOD}) : res_dbl[4:0];
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/gregorian_date_decrement.sv -----
// top level of the gregorian date decrement block
`default_nettype none

// Moves a Gregorian date back by count days, weeks, months, years, decades,
// centuries or millennia, one request at a time. Day, week and month requests
// run on one shared step unit: after the request is taken, the year is folded
// into its residue mod 25 (used for the leap test) one bit at a time, then the
// unit takes one step per day (7 per week) or per month. Year-based units, the
// unused unit code and a zero count skip the step unit and use one 16 by 16
// multiply. A finished date sits in the output register while the next request
// is accepted. The year wraps modulo 2^16; day 0 is read as 1 and month 0 or
// 13..15 as 1 or 12.
module gregorian_date_decrement #(
  parameter int COUNT_BITS = gdd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            mode,
  input  wire logic [COUNT_BITS-1:0] count,
  input  wire logic [4:0]            day_in,
  input  wire logic [3:0]            month_in,
  input  wire logic signed [15:0]    year_in,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [4:0]                 day_out,
  output logic [3:0]                 month_out,
  output logic signed [15:0]         year_out
);

  `include "assert_macros.svh"

  localparam int STEP_BITS = COUNT_BITS + 3;
  localparam int BCNT_BITS = $clog2(gdd_pkg::RES_BITS);

  gdd_pkg::state_t   state, state_next;
  gdd_pkg::mode_t    mode_r;
  gdd_pkg::mode_t    mode_in;
  gdd_pkg::step_op_t op;
  gdd_pkg::date_t    work, step_nxt;

  logic [STEP_BITS-1:0]          steps;
  logic [STEP_BITS-1:0]          steps_init;
  logic [gdd_pkg::RES_BITS-1:0]  shreg;
  logic [BCNT_BITS-1:0]          bcnt;
  logic                          accept;
  logic                          out_free;
  logic                          load_out;
  logic                          iterate;
  logic                          year_mode;
  logic [4:0]                    day_fix;
  logic [3:0]                    month_fix;
  logic [15:0]                   year_sub;
  logic [4:0]                    day_r;
  logic [3:0]                    month_r;
  logic [15:0]                   year_r;

  // request decode and input fix-ups
  always_comb begin
    mode_in    = gdd_pkg::mode_t'(mode);
    steps_init = (mode_in == gdd_pkg::MODE_WEEK) ?
                 ((STEP_BITS'(count) << 3) - STEP_BITS'(count)) : STEP_BITS'(count);
    year_mode  = (mode_in == gdd_pkg::MODE_YEAR) || (mode_in == gdd_pkg::MODE_DECADE) ||
                 (mode_in == gdd_pkg::MODE_CENTURY) || (mode_in == gdd_pkg::MODE_MILLENNIUM);
    // day, week and month requests with work to do go through the step unit
    iterate    = ((mode_in == gdd_pkg::MODE_DAY) || (mode_in == gdd_pkg::MODE_WEEK) ||
                  (mode_in == gdd_pkg::MODE_MONTH)) && (steps_init != '0);
    day_fix    = (day_in == 5'd0) ? 5'd1 : day_in;
    month_fix  = (month_in == 4'd0) ? gdd_pkg::MONTH_JAN :
                 ((month_in > gdd_pkg::MONTH_DEC) ? gdd_pkg::MONTH_DEC : month_in);
    // scaled year count, kept to 16 bits as the year wraps anyway
    year_sub   = 16'(16'(count) * gdd_pkg::year_scale(mode_in));
  end

  assign in_stall = (state != gdd_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // sequencer
  always_comb begin
    state_next = state;
    op         = gdd_pkg::OP_RES;
    load_out   = 1'b0;
    unique case (state)
      gdd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = iterate ? gdd_pkg::ST_RES : gdd_pkg::ST_DONE;
        end
      end
      gdd_pkg::ST_RES: begin
        op = gdd_pkg::OP_RES;
        if (bcnt == '0) begin
          state_next = gdd_pkg::ST_STEP;
        end
      end
      gdd_pkg::ST_STEP: begin
        op = (mode_r == gdd_pkg::MODE_MONTH) ? gdd_pkg::OP_MONTH : gdd_pkg::OP_DAY;
        if (steps == STEP_BITS'(1)) begin
          state_next = gdd_pkg::ST_DONE;
        end
      end
      gdd_pkg::ST_DONE: begin
        // hand over once the output register is free
        if (out_free) begin
          load_out   = 1'b1;
          state_next = gdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gdd_pkg::ST_IDLE;
      end
    endcase
  end

  gdd_step u_step (
    .op     (op),
    .cur    (work),
    .bit_in (shreg[gdd_pkg::RES_BITS-1]),
    .nxt    (step_nxt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gdd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= mode_in;
      steps      <= steps_init;
      shreg      <= year_in[gdd_pkg::RES_BITS-1:0];
      bcnt       <= BCNT_BITS'(gdd_pkg::RES_BITS - 1);
      work.day   <= day_fix;
      work.month <= month_fix;
      work.year  <= year_mode ? (year_in - year_sub) : year_in;
      // the sign bit weighs -2^15, seeded as -1 before the doublings
      work.res   <= year_in[15] ? (gdd_pkg::RES_MOD - 5'd1) : 5'd0;
    end else if (state == gdd_pkg::ST_RES) begin
      work  <= step_nxt;
      shreg <= shreg << 1;
      bcnt  <= bcnt - BCNT_BITS'(1);
    end else if (state == gdd_pkg::ST_STEP) begin
      work  <= step_nxt;
      steps <= steps - STEP_BITS'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      day_r   <= work.day;
      month_r <= work.month;
      year_r  <= work.year;
    end
  end

  assign day_out   = day_r;
  assign month_out = month_r;
  assign year_out  = year_r;

  `ASSERT_CLK(a_accept_leaves_idle, accept |=> (state != gdd_pkg::ST_IDLE),
    "accepted request did not start work")
  `ASSERT_CLK(a_step_has_work, (state == gdd_pkg::ST_STEP) |-> (steps != '0),
    "step state entered with no steps left")
  `ASSERT_CLK(a_iter_mode, (state == gdd_pkg::ST_RES) |-> ((mode_r == gdd_pkg::MODE_DAY) ||
    (mode_r == gdd_pkg::MODE_WEEK) || (mode_r == gdd_pkg::MODE_MONTH)),
    "iterating on a year-based unit")
  `ASSERT_CLK(a_res_range, (state == gdd_pkg::ST_STEP) |-> (work.res < gdd_pkg::RES_MOD),
    "year residue out of range")
  `ASSERT_CLK(a_month_range, (state == gdd_pkg::ST_STEP) |->
    ((work.month >= gdd_pkg::MONTH_JAN) && (work.month <= gdd_pkg::MONTH_DEC)),
    "working month out of range")

endmodule

`default_nettype wire

// ----- bench/gdd_checker.sv -----
// checker that predicts and compares the dates leaving the date decrement block
module gdd_checker
  import gdd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [2:0]            mode,
  input  wire logic [COUNT_BITS-1:0] count,
  input  wire logic [4:0]            day_in,
  input  wire logic [3:0]            month_in,
  input  wire logic signed [15:0]    year_in,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [4:0]            day_out,
  input  wire logic [3:0]            month_out,
  input  wire logic signed [15:0]    year_out,
  output int                         fail_count,
  output int                         dates_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic signed [15:0] year;
  } cal_date_t;

  cal_date_t owed_dates[$];
  int        miss_total = 0;

  function automatic bit leap_year(input logic signed [15:0] yr);
    int s;
    s = yr;
    return ((s % 4 == 0) && (s % 100 != 0)) || (s % 400 == 0);
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] mon,
                                              input logic signed [15:0] yr);
    case (mon)
      MONTH_FEB:              return leap_year(yr) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                return DAY_LAST;
    endcase
  endfunction

  function automatic cal_date_t earlier_date(input mode_t md, input logic [COUNT_BITS-1:0] cnt,
                                             input logic [4:0] d, input logic [3:0] m,
                                             input logic signed [15:0] y);
    cal_date_t   r;
    int          steps;
    logic [31:0] scaled;
    r.day   = (d == 5'd0) ? 5'd1 : d;
    r.month = (m == 4'd0) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m);
    r.year  = y;
    case (md)
      MODE_DAY, MODE_WEEK: begin
        steps = (md == MODE_WEEK) ? int'(cnt) * 7 : int'(cnt);
        for (int i = 0; i < steps; i++) begin
          if (r.day <= 5'd1) begin
            if (r.month <= MONTH_JAN) begin
              r.month = MONTH_DEC;
              r.day   = DAY_LAST;
              r.year  = r.year - 16'sd1;
            end else begin
              r.month = r.month - 4'd1;
              r.day   = month_length(r.month, r.year);
            end
          end else begin
            r.day = r.day - 5'd1;
          end
        end
      end
      MODE_MONTH: begin
        for (int i = 0; i < int'(cnt); i++) begin
          if (r.month <= MONTH_JAN) begin
            r.month = MONTH_DEC;
            r.year  = r.year - 16'sd1;
          end else begin
            r.month = r.month - 4'd1;
          end
          if (r.day > month_length(r.month, r.year)) r.day = month_length(r.month, r.year);
        end
      end
      MODE_YEAR, MODE_DECADE, MODE_CENTURY, MODE_MILLENNIUM: begin
        case (md)
          MODE_DECADE:     scaled = 32'(cnt) * 32'd10;
          MODE_CENTURY:    scaled = 32'(cnt) * 32'd100;
          MODE_MILLENNIUM: scaled = 32'(cnt) * 32'd1000;
          default:         scaled = 32'(cnt);
        endcase
        r.year = r.year - scaled[15:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_miss(input string what, input cal_date_t want, input cal_date_t got);
    if (miss_total < 10)
      $display("%0t %s: expected %0d-%0d-%0d got %0d-%0d-%0d", $realtime, what,
               want.year, want.month, want.day, got.year, got.month, got.day);
    miss_total++;
  endtask

  always @(posedge clk) begin
    cal_date_t want;
    cal_date_t got;
    if (!rst) begin
      // results leave before the next request enters, so pop first
      if (out_valid && !out_stall) begin
        got = '{day: day_out, month: month_out, year: year_out};
        if (owed_dates.size() == 0) begin
          report_miss("date with no request waiting", '0, got);
        end else begin
          want = owed_dates.pop_front();
          if (got.day !== want.day || got.month !== want.month || got.year !== want.year)
            report_miss("date mismatch", want, got);
        end
      end
      if (in_valid && !in_stall)
        owed_dates.push_back(earlier_date(mode_t'(mode), count, day_in, month_in, year_in));
    end
    fail_count <= miss_total;
    dates_owed <= owed_dates.size();
  end

endmodule

// ----- bench/tb_gregorian_date_decrement.sv -----
// top of the date decrement testbench: stimulus, receiver pacing and verdict
module tb_gregorian_date_decrement;
  timeunit 1ns;
  timeprecision 1ps;
  import gdd_pkg::*;

  localparam int COUNT_BITS     = 12;
  // long receiver hold-off that fills the block and backs up the request side
  localparam int HOLD_CYCLES    = 300;
  // well above the longest run of a week request of full count
  localparam int WATCHDOG_LIMIT = 200000;
  // a year-type or zero-count request skips the step unit, so this is ample
  localparam int TAIL_CYCLES    = 40;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            req_mode = '0;
  logic [COUNT_BITS-1:0] req_count = '0;
  logic [4:0]            req_day = '0;
  logic [3:0]            req_month = '0;
  logic signed [15:0]    req_year = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [4:0]            day_out;
  logic [3:0]            month_out;
  logic signed [15:0]    year_out;

  int fail_count;
  int dates_owed;

  // pacing knobs, percent of cycles spent idle on each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long hold-off requests from the stimulus; the receiver acknowledges them
  int hold_req  = 0;
  int hold_done = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  gregorian_date_decrement #(
    .COUNT_BITS (COUNT_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (req_mode),
    .count     (req_count),
    .day_in    (req_day),
    .month_in  (req_month),
    .year_in   (req_year),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .day_out   (day_out),
    .month_out (month_out),
    .year_out  (year_out)
  );

  gdd_checker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (req_mode),
    .count      (req_count),
    .day_in     (req_day),
    .month_in   (req_month),
    .year_in    (req_year),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .day_out    (day_out),
    .month_out  (month_out),
    .year_out   (year_out),
    .fail_count (fail_count),
    .dates_owed (dates_owed)
  );

  // receiver: random stalls, or one long hold-off counted here when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_done + 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog: too long with neither channel moving means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one request, after a random gap, and hold it until taken
  task automatic offer_date(input mode_t md, input logic [COUNT_BITS-1:0] cnt,
                            input logic [4:0] d, input logic [3:0] m,
                            input logic [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_mode  <= md;
    req_count <= cnt;
    req_day   <= d;
    req_month <= m;
    req_year  <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // mostly well-formed dates with small counts on the slow stepping units
  task automatic offer_random_date(input bit year_units_only);
    mode_t                 md;
    logic [COUNT_BITS-1:0] cnt;
    logic [4:0]            d;
    logic [3:0]            m;
    logic [15:0]           y;
    int                    pick;
    if (year_units_only)
      md = mode_t'($urandom_range(int'(MODE_MILLENNIUM), int'(MODE_YEAR)));
    else
      md = mode_t'($urandom_range(7));
    pick = $urandom_range(99);
    if (md == MODE_DAY || md == MODE_WEEK || md == MODE_MONTH) begin
      // the block steps once per day or month, so keep most counts short
      if (pick < 90)      cnt = COUNT_BITS'($urandom_range(40));
      else if (pick < 98) cnt = COUNT_BITS'($urandom_range(400));
      else                cnt = COUNT_BITS'($urandom);
    end else begin
      cnt = COUNT_BITS'($urandom);
    end
    // years: anywhere, around the 16-bit wrap, or on century boundaries
    pick = $urandom_range(99);
    if (pick < 50)      y = 16'($urandom);
    else if (pick < 70) y = 16'h7FF8 + 16'($urandom_range(15));
    else                y = 16'(int'($urandom_range(654)) * 100 - 32700);
    pick = $urandom_range(99);
    if (pick < 80) begin
      m = 4'($urandom_range(12, 1));
      d = ($urandom_range(99) < 30) ? 5'd1 : 5'($urandom_range(31, 1));
      if (m == MONTH_FEB && d > 5'd29) d = 5'd29;
      else if ((m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) && d == DAY_LAST) d = 5'd30;
    end else begin
      // out-of-range day and month codes
      m = 4'($urandom_range(15));
      d = 5'($urandom_range(31));
    end
    offer_date(md, cnt, d, m, y);
  endtask

  // stop offering and wait until every owed date has come back
  task automatic drain_dates();
    in_valid <= 1'b0;
    do @(posedge clk); while (dates_owed != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first pacing: sender idles a little, receiver a lot
    send_idle_pct = 20;
    recv_idle_pct = 68;

    // directed requests
    // zero count with day 0 and month 0 fixed up to 1 January
    offer_date(MODE_DAY, 12'd0, 5'd0, 4'd0, 16'sd0);
    // year wrap going back one day from 1 January of the lowest year
    offer_date(MODE_DAY, 12'd1, 5'd1, MONTH_JAN, 16'sh8000);
    // leap rules: divisible by 400, by 100 only, by 4, and negative years
    offer_date(MODE_DAY, 12'd1, 5'd1, 4'd3, 16'sd2000);
    offer_date(MODE_DAY, 12'd1, 5'd1, 4'd3, 16'sd1900);
    offer_date(MODE_DAY, 12'd1, 5'd1, 4'd3, 16'sd2024);
    offer_date(MODE_DAY, 12'd1, 5'd1, 4'd3, -16'sd4);
    offer_date(MODE_DAY, 12'd1, 5'd1, 4'd3, -16'sd100);
    offer_date(MODE_DAY, 12'd1, 5'd1, 4'd3, -16'sd400);
    // day past month end just counts down
    offer_date(MODE_DAY, 12'd1, 5'd30, MONTH_FEB, 16'sd2023);
    offer_date(MODE_DAY, 12'd3, 5'd0, 4'd5, 16'sd7);
    // month above 12 read as December, longest week run
    offer_date(MODE_WEEK, 12'hFFF, DAY_LAST, 4'd15, 16'sh7FFF);
    offer_date(MODE_DAY, 12'hFFF, DAY_LAST, 4'd4, -16'sd1);
    // month steps clamp the day
    offer_date(MODE_MONTH, 12'd1, DAY_LAST, 4'd3, 16'sd2023);
    offer_date(MODE_MONTH, 12'd1, 5'd15, MONTH_JAN, 16'sh8000);
    offer_date(MODE_MONTH, 12'hFFF, DAY_LAST, 4'd13, -16'sd1);
    // 29 February kept into a year that is not leap
    offer_date(MODE_YEAR, 12'd1, 5'd29, MONTH_FEB, 16'sd2024);
    offer_date(MODE_YEAR, 12'd0, 5'd0, 4'd0, 16'sh7FFF);
    offer_date(MODE_DECADE, 12'hFFF, 5'd10, 4'd6, 16'sd0);
    offer_date(MODE_CENTURY, 12'hFFF, 5'd31, MONTH_DEC, 16'sh7FFF);
    offer_date(MODE_MILLENNIUM, 12'hFFF, 5'd1, MONTH_JAN, 16'sh8000);
    // unused unit code passes the fixed-up date through
    offer_date(MODE_NONE, 12'd5, DAY_LAST, 4'd15, 16'sd1234);
    drain_dates();

    // random part, first pacing
    repeat (450) offer_random_date(1'b0);
    drain_dates();

    // second pacing: the other way round
    send_idle_pct = 68;
    recv_idle_pct = 20;
    repeat (450) offer_random_date(1'b0);
    drain_dates();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (220) offer_random_date(1'b0);
    // receiver holds off while fast requests keep coming, so input stalls
    hold_req <= hold_req + 1;
    repeat (12) offer_random_date(1'b1);
    repeat (220) offer_random_date(1'b0);
    drain_dates();

    // give a stray extra result time to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
